FILE: rtl/core/blh_pkg.sv
// Shared types and constants for the battery level hysteresis core.
// No dependencies; imported by the core, blh_cfg_regs, blh_update and the testbench.
package blh_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned REG_W    = 48;
  localparam int unsigned NUM_THR  = 4;
  localparam int unsigned IDX_W    = 2;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CHG_SET = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHG_REL = 2'd1;
  localparam logic [IDX_W-1:0] REG_DIS_SET = 2'd2;
  localparam logic [IDX_W-1:0] REG_DIS_REL = 2'd3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef sample_t [NUM_THR-1:0] thr_set_t;

  typedef struct packed {
    thr_set_t chg_set;
    thr_set_t chg_rel;
    thr_set_t dis_set;
    thr_set_t dis_rel;
  } thr_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] chg_flags;
    logic [LEVEL_W-1:0] dis_flags;
    logic               uv;
  } flag_state_t;

  typedef struct packed {
    sample_t sample;
    logic    charging;
    logic    charge_done;
  } sample_word_t;

endpackage

FILE: rtl/core/battery_level_hysteresis_core.sv
// Battery level indicator with hysteresis: input register, flag update, result register.
// An accepted word moves from the input register to the result register, which then raises m_tvalid;
// one word per cycle sustained while the output is not back-pressured,
// set by the single flag-state register updated as each word leaves the input stage.
// Synchronous active-high rst clears thresholds, flags and both valid bits.
// Depends on blh_pkg, blh_cfg_regs, blh_update.
module battery_level_hysteresis_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [blh_pkg::IN_DATA_W-1:0]  s_tdata,  // [11:0] battery_sample, zero pad
  input  logic [blh_pkg::IN_USER_W-1:0]  s_tuser,  // [0] charging, [1] charge_done
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [blh_pkg::OUT_DATA_W-1:0] m_tdata,  // [3:0] level_display, [4] under_voltage
  input  logic                           cfg_we,
  input  logic [blh_pkg::IDX_W-1:0]      cfg_index,
  input  logic [blh_pkg::REG_W-1:0]      cfg_wdata
);
  import blh_pkg::*;

  thr_cfg_t     thr;
  flag_state_t  state;
  flag_state_t  state_next;
  sample_word_t in_word;
  logic         in_valid;
  logic         advance;
  logic [LEVEL_W-1:0] out_level;
  logic               out_uv;

  blh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  blh_update u_update (
    .thr     (thr),
    .cur     (state),
    .word_in (in_word),
    .nxt     (state_next)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word.sample      <= s_tdata[SAMPLE_W-1:0];
      in_word.charging    <= s_tuser[0];
      in_word.charge_done <= s_tuser[1];
    end
  end

  // flag state commits only when the word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        state    <= state_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level <= in_word.charging ? state_next.chg_flags : state_next.dis_flags;
      out_uv    <= state_next.uv;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-LEVEL_W-1){1'b0}}, out_uv, out_level};

endmodule

FILE: rtl/core/blh_cfg_regs.sv
// Threshold register file: four 48-bit registers of four 12-bit fields each.
// Depends on blh_pkg.
module blh_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [blh_pkg::IDX_W-1:0] cfg_index,
  input  logic [blh_pkg::REG_W-1:0] cfg_wdata,
  output blh_pkg::thr_cfg_t         thr
);
  import blh_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHG_SET: thr.chg_set <= thr_set_t'(cfg_wdata);
        REG_CHG_REL: thr.chg_rel <= thr_set_t'(cfg_wdata);
        REG_DIS_SET: thr.dis_set <= thr_set_t'(cfg_wdata);
        REG_DIS_REL: thr.dis_rel <= thr_set_t'(cfg_wdata);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/blh_update.sv
// Next-state logic for the sticky level flags: one compare-and-update step.
// Depends on blh_pkg.
module blh_update (
  input  blh_pkg::thr_cfg_t    thr,
  input  blh_pkg::flag_state_t cur,
  input  blh_pkg::sample_word_t word_in,
  output blh_pkg::flag_state_t nxt
);
  import blh_pkg::*;

  sample_t            v;
  logic [LEVEL_W-1:0] f;
  logic [LEVEL_W-1:0] d;
  logic               uv;

  assign v = word_in.sample;

  always_comb begin
    f  = cur.chg_flags;
    d  = cur.dis_flags;
    uv = cur.uv;
    if (word_in.charging) begin
      // raise highest qualifying level, full first
      priority if (v > thr.chg_set[3] || word_in.charge_done || f[3]) f[3] = 1'b1;
      else if (v >= thr.chg_set[2] || f[2]) f[2] = 1'b1;
      else if (v >= thr.chg_set[1] || f[1]) f[1] = 1'b1;
      else if (v >= thr.chg_set[0] || f[0]) f[0] = 1'b1;
      for (int k = 0; k < NUM_THR; k++) begin
        if (v < thr.chg_rel[k]) f[k] = 1'b0;
      end
    end else begin
      // lowest active level masks those above it
      priority if (v <= thr.dis_set[0] || uv) begin
        uv = 1'b1;
        d  = '0;
      end else if (v <= thr.dis_set[1] || d[0]) begin
        d = 4'b0001;
      end else if (v <= thr.dis_set[2] || d[1]) begin
        d = {2'b00, 1'b1, d[0]};
      end else if (v <= thr.dis_set[3] || d[2]) begin
        d = {1'b0, 1'b1, d[1:0]};
      end else begin
        d[3] = 1'b1;
      end
      if (v > thr.dis_rel[0]) uv = 1'b0;
      for (int k = 1; k < NUM_THR; k++) begin
        if (v > thr.dis_rel[k]) d[k-1] = 1'b0;
      end
    end
    nxt.chg_flags = f;
    nxt.dis_flags = d;
    nxt.uv        = uv;
  end

endmodule

FILE: rtl/core/blh_checker.sv
// Port-level checks for battery_level_hysteresis_core, bound to the top level.
// Depends on battery_level_hysteresis_core port list.
module blh_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // input side only stalls when the result register is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // a fresh result must trace back to an accepted word
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without an accepted word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind battery_level_hysteresis_core blh_checker u_blh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: sim/tb_battery_level_hysteresis_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for battery_level_hysteresis_core: predicts level/undervoltage words
// and compares them in order. Depends on blh_pkg and the core RTL only.
module tb_battery_level_hysteresis_core;
  import blh_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 320;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               uv;
  } gauge_reading_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [IN_USER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [REG_W-1:0]      cfg_wdata = '0;

  // predictor state
  thr_cfg_t           thr_model     = '0;
  logic [LEVEL_W-1:0] chg_flags_mdl = '0;
  logic [LEVEL_W-1:0] dis_flags_mdl = '0;
  logic               uv_mdl        = 1'b0;

  gauge_reading_t pending_readings[$];
  int fault_count  = 0;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int hold_token   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int idle_cycles  = 0;

  always #2 clk = ~clk;

  battery_level_hysteresis_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic gauge_reading_t update_gauge(sample_t v, logic chg, logic done);
    logic [LEVEL_W-1:0] f;
    gauge_reading_t     r;
    if (chg) begin
      f = chg_flags_mdl;
      // highest level that applies wins; held flags keep their level
      if (v > thr_model.chg_set[3] || done || f[3]) f[3] = 1'b1;
      else if (v >= thr_model.chg_set[2] || f[2]) f[2] = 1'b1;
      else if (v >= thr_model.chg_set[1] || f[1]) f[1] = 1'b1;
      else if (v >= thr_model.chg_set[0] || f[0]) f[0] = 1'b1;
      for (int k = 0; k < NUM_THR; k++)
        if (v < thr_model.chg_rel[k]) f[k] = 1'b0;
      chg_flags_mdl = f;
    end else begin
      f = dis_flags_mdl;
      if (v <= thr_model.dis_set[0] || uv_mdl) begin
        uv_mdl = 1'b1;
        f = '0;
      end else if (v <= thr_model.dis_set[1] || f[0]) begin
        f = 4'h1;
      end else if (v <= thr_model.dis_set[2] || f[1]) begin
        f = (f | 4'h2) & 4'h3;
      end else if (v <= thr_model.dis_set[3] || f[2]) begin
        f = (f | 4'h4) & 4'h7;
      end else begin
        f[3] = 1'b1;
      end
      if (v > thr_model.dis_rel[0]) uv_mdl = 1'b0;
      // above-75% flag has no release threshold
      for (int k = 1; k < NUM_THR; k++)
        if (v > thr_model.dis_rel[k]) f[k-1] = 1'b0;
      dis_flags_mdl = f;
    end
    r.level = f;
    r.uv    = uv_mdl;
    return r;
  endfunction

  function automatic logic [REG_W-1:0] pack_levels(sample_t t0, sample_t t1, sample_t t2,
                                                   sample_t t3);
    return {t3, t2, t1, t0};
  endfunction

  // leaves cfg_we high so writes can go back to back
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CHG_SET: thr_model.chg_set = val;
      REG_CHG_REL: thr_model.chg_rel = val;
      REG_DIS_SET: thr_model.dis_set = val;
      REG_DIS_REL: thr_model.dis_rel = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_thresholds(input logic [REG_W-1:0] chg_set, chg_rel, dis_set,
                                    dis_rel);
    write_reg(REG_CHG_SET, chg_set);
    write_reg(REG_CHG_REL, chg_rel);
    write_reg(REG_DIS_SET, dis_set);
    write_reg(REG_DIS_REL, dis_rel);
    cfg_we <= 1'b0;
  endtask

  // ordered ladders with hysteresis, or raw random words
  task automatic program_random_levels(input bit raw);
    int      cb, cstep, db, dstep;
    sample_t cs[NUM_THR];
    sample_t cr[NUM_THR];
    sample_t ds[NUM_THR];
    sample_t dr[NUM_THR];
    if (raw) begin
      program_thresholds(REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                         REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}));
    end else begin
      cb    = $urandom_range(200, 1500);
      cstep = $urandom_range(100, 600);
      db    = $urandom_range(200, 1200);
      dstep = $urandom_range(100, 600);
      for (int k = 0; k < NUM_THR; k++) begin
        cs[k] = sample_t'(cb + k * cstep);
        cr[k] = sample_t'(cb + k * cstep - int'($urandom_range(150)));
        ds[k] = sample_t'(db + k * dstep);
        dr[k] = sample_t'(db + k * dstep + int'($urandom_range(150)));
      end
      program_thresholds(pack_levels(cs[0], cs[1], cs[2], cs[3]),
                         pack_levels(cr[0], cr[1], cr[2], cr[3]),
                         pack_levels(ds[0], ds[1], ds[2], ds[3]),
                         pack_levels(dr[0], dr[1], dr[2], dr[3]));
    end
  endtask

  // returns right after the edge that accepted the word; tvalid stays up
  task automatic send_word(input sample_t v, input logic chg, input logic done);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-SAMPLE_W){1'b0}}, v};
    s_tuser  <= {done, chg};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_readings.push_back(update_gauge(v, chg, done));
  endtask

  task automatic wait_drained;
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_zero_thresholds;
    send_word(12'd0, 1'b1, 1'b0);
    send_word(12'hFFF, 1'b0, 1'b0);
    send_word(12'd0, 1'b0, 1'b0);
    wait_drained;
  endtask

  task automatic test_charge_levels;
    program_thresholds(pack_levels(12'd2600, 12'd3000, 12'd3400, 12'd3800),
                       pack_levels(12'd2500, 12'd2900, 12'd3300, 12'd3700),
                       pack_levels(12'd2000, 12'd2400, 12'd2800, 12'd3200),
                       pack_levels(12'd2100, 12'd2500, 12'd2900, 12'd3300));
    send_word(12'd2000, 1'b1, 1'b0);
    send_word(12'd2600, 1'b1, 1'b0);
    send_word(12'd3000, 1'b1, 1'b0);
    send_word(12'd3400, 1'b1, 1'b0);
    send_word(12'd3801, 1'b1, 1'b0);
    send_word(12'd3750, 1'b1, 1'b0);
    send_word(12'd3650, 1'b1, 1'b0);
    send_word(12'd100, 1'b1, 1'b1);
    // charge_done with no charger present
    send_word(12'd3000, 1'b0, 1'b1);
    wait_drained;
  endtask

  task automatic test_discharge_levels;
    send_word(12'hFFF, 1'b0, 1'b0);
    send_word(12'd3100, 1'b0, 1'b0);
    send_word(12'd2700, 1'b0, 1'b0);
    send_word(12'd2300, 1'b0, 1'b0);
    send_word(12'd1900, 1'b0, 1'b0);
    send_word(12'd2050, 1'b0, 1'b0);
    // undervoltage must hold while charging
    send_word(12'd2200, 1'b1, 1'b0);
    send_word(12'd2200, 1'b0, 1'b0);
    send_word(12'd3400, 1'b0, 1'b0);
    wait_drained;
  endtask

  task automatic test_saturated_thresholds;
    program_thresholds('1, '1, '1, '1);
    send_word(12'hFFF, 1'b1, 1'b0);
    send_word(12'd0, 1'b1, 1'b0);
    send_word(12'd0, 1'b0, 1'b0);
    send_word(12'hFFF, 1'b0, 1'b0);
    wait_drained;
  endtask

  // mostly charge/discharge runs with a drifting sample, some noise words
  task automatic test_random_phase(input int sgap, input int rgap, input bit raw_cfg);
    int   v;
    int   run_left;
    logic chg;
    logic done;
    send_gap_pct = sgap;
    recv_gap_pct = rgap;
    program_random_levels(raw_cfg);
    v        = $urandom_range(4095);
    run_left = 0;
    chg      = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(5, 40);
        chg      = 1'($urandom_range(1));
      end
      run_left--;
      if ($urandom_range(99) < 15) begin
        send_word(sample_t'($urandom_range(4095)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        if (chg) v = v + int'($urandom_range(450)) - 150;
        else     v = v + int'($urandom_range(450)) - 300;
        if (v < 0)    v = 0;
        if (v > 4095) v = 4095;
        done = chg && ($urandom_range(99) < 8);
        send_word(sample_t'(v), chg, done);
      end
    end
    wait_drained;
  endtask

  task automatic test_output_backpressure;
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_token++;
    for (int n = 0; n < 40; n++)
      send_word(sample_t'($urandom_range(4095)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    wait_drained;
  endtask

  // receiver: random stalls, plus long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      gauge_reading_t got;
      gauge_reading_t want;
      got.level = m_tdata[LEVEL_W-1:0];
      got.uv    = m_tdata[LEVEL_W];
      if (pending_readings.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("unexpected output word %h at %0t", m_tdata, $realtime);
      end else begin
        want = pending_readings.pop_front();
        if (got.level !== want.level || got.uv !== want.uv) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("mismatch at %0t: level exp %h got %h, uv exp %b got %b",
                     $realtime, want.level, got.level, want.uv, got.uv);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_battery_level_hysteresis_core NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_zero_thresholds;
    test_charge_levels;
    test_discharge_levels;
    test_saturated_thresholds;
    test_random_phase(23, 84, 1'b0);
    test_random_phase(84, 23, 1'b1);
    test_random_phase(0, 0, 1'b0);
    test_output_backpressure;
    repeat (8) @(posedge clk);
    fault_count += pending_readings.size();
    if (fault_count == 0) $display("tb_battery_level_hysteresis_core OK");
    else                  $display("tb_battery_level_hysteresis_core NOT OK");
    $finish;
  end

endmodule
